FILE: sv/nfc_pkg.sv
`timescale 1ns / 1ps
// nfc_pkg: shared types, mode codes and a leading zero helper for the numeric format converter
// no dependencies

package nfc_pkg;

	localparam int unsigned ModeW = 4;

	typedef enum logic [ModeW-1:0] {
		MODE_U8_F64   = 4'd0,
		MODE_I16_F64  = 4'd1,
		MODE_F64_U32  = 4'd2,
		MODE_F32_U32  = 4'd3,
		MODE_U8_F32   = 4'd4,
		MODE_I16_F32  = 4'd5,
		MODE_F64_U8   = 4'd6,
		MODE_F64_I16  = 4'd7,
		MODE_U32_F64  = 4'd8,
		MODE_U32_F32  = 4'd9,
		MODE_F32_U8   = 4'd10,
		MODE_F32_I16  = 4'd11
	} mode_t;

	typedef enum logic [2:0] {
		DST_F64,
		DST_F32,
		DST_U32,
		DST_U8,
		DST_I16,
		DST_BAD
	} dst_t;

	// stage 1: unpacked operand
	typedef struct packed {
		dst_t        dst;
		logic        nan;
		logic        sign;
		logic        fbig;
		logic        fsmall;
		logic [5:0]  fsh;
		logic [52:0] fmant;
		logic [31:0] imag;
		logic [4:0]  ilz;
		logic        izero;
		logic        last;
	} s1_t;

	// stage 2: aligned operand
	typedef struct packed {
		dst_t        dst;
		logic        nan;
		logic        sign;
		logic        fbig;
		logic [31:0] fmag;
		logic [31:0] inorm;
		logic [4:0]  iexp;
		logic        izero;
		logic        last;
	} s2_t;

	// stage 3: finished word
	typedef struct packed {
		logic [63:0] bits;
		logic        flag;
		logic        last;
	} s3_t;

	function automatic logic [4:0] lead_zeros(input logic [31:0] v);
		logic [4:0] n;
		n = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) n = 5'(31 - i);
		end
		return n;
	endfunction

endpackage

FILE: sv/nfc_unpack.sv
`timescale 1ns / 1ps
// nfc_unpack: mode decode, float field split and integer magnitude with leading zero count
// depends on nfc_pkg

module nfc_unpack import nfc_pkg::*; (
	input  logic [ModeW-1:0] mode,
	input  logic [63:0]      source_bits,
	input  logic             last_in,
	output s1_t              s1
);
	logic               src_f64, src_f32, src_u8, src_i16;
	logic [10:0]        ef;
	logic [7:0]         es;
	logic signed [12:0] e;
	logic [15:0]        neg16;

	always_comb begin
		src_f64 = 1'b0;
		src_f32 = 1'b0;
		src_u8 = 1'b0;
		src_i16 = 1'b0;
		s1.dst = DST_BAD;
		case (mode_t'(mode))
			MODE_U8_F64: begin src_u8 = 1'b1; s1.dst = DST_F64; end
			MODE_I16_F64: begin src_i16 = 1'b1; s1.dst = DST_F64; end
			MODE_F64_U32: begin src_f64 = 1'b1; s1.dst = DST_U32; end
			MODE_F32_U32: begin src_f32 = 1'b1; s1.dst = DST_U32; end
			MODE_U8_F32: begin src_u8 = 1'b1; s1.dst = DST_F32; end
			MODE_I16_F32: begin src_i16 = 1'b1; s1.dst = DST_F32; end
			MODE_F64_U8: begin src_f64 = 1'b1; s1.dst = DST_U8; end
			MODE_F64_I16: begin src_f64 = 1'b1; s1.dst = DST_I16; end
			MODE_U32_F64: s1.dst = DST_F64;
			MODE_U32_F32: s1.dst = DST_F32;
			MODE_F32_U8: begin src_f32 = 1'b1; s1.dst = DST_U8; end
			MODE_F32_I16: begin src_f32 = 1'b1; s1.dst = DST_I16; end
			default: s1.dst = DST_BAD;
		endcase

		ef = source_bits[62:52];
		es = source_bits[30:23];
		neg16 = 16'(~source_bits[15:0] + 16'd1);
		if (src_f32) begin
			e = (es == 8'd0) ? -13'sd126 : ($signed({5'b0, es}) - 13'sd127);
			s1.fmant = {es != 8'd0, source_bits[22:0], 29'b0};
			s1.nan = (es == 8'hff) && (source_bits[22:0] != 23'd0);
		end else begin
			e = (ef == 11'd0) ? -13'sd1022 : ($signed({2'b0, ef}) - 13'sd1023);
			s1.fmant = {ef != 11'd0, source_bits[51:0]};
			s1.nan = (ef == 11'h7ff) && (source_bits[51:0] != 52'd0);
		end
		s1.fbig = (e >= 13'sd32);
		s1.fsmall = e[12];
		s1.fsh = 6'(13'sd52 - e);

		if (src_u8) begin
			s1.imag = {24'b0, source_bits[7:0]};
			s1.sign = 1'b0;
		end else if (src_i16) begin
			s1.imag = {16'b0, source_bits[15] ? neg16 : source_bits[15:0]};
			s1.sign = source_bits[15];
		end else if (src_f64) begin
			s1.imag = source_bits[31:0];
			s1.sign = source_bits[63];
		end else if (src_f32) begin
			s1.imag = source_bits[31:0];
			s1.sign = source_bits[31];
		end else begin
			s1.imag = source_bits[31:0];
			s1.sign = 1'b0;
		end
		s1.ilz = lead_zeros(s1.imag);
		s1.izero = (s1.imag == 32'd0);
		s1.last = last_in;
	end
endmodule

FILE: sv/nfc_align.sv
`timescale 1ns / 1ps
// nfc_align: integer part extraction and integer normalization shifts
// depends on nfc_pkg

module nfc_align import nfc_pkg::*; (
	input  s1_t s1,
	output s2_t s2
);
	always_comb begin
		s2.dst = s1.dst;
		s2.nan = s1.nan;
		s2.sign = s1.sign;
		s2.fbig = s1.fbig;
		s2.fmag = s1.fsmall ? 32'd0 : 32'(s1.fmant >> s1.fsh);
		s2.inorm = s1.imag << s1.ilz;
		s2.iexp = 5'd31 - s1.ilz;
		s2.izero = s1.izero;
		s2.last = s1.last;
	end
endmodule

FILE: sv/nfc_pack.sv
`timescale 1ns / 1ps
// nfc_pack: float packing with rounding for f32, integer saturation and flag
// depends on nfc_pkg

module nfc_pack import nfc_pkg::*; (
	input  s2_t s2,
	output s3_t s3
);
	logic        rnd;
	logic [30:0] sgl;
	logic [15:0] neg16;

	always_comb begin
		rnd = s2.inorm[7] && ((s2.inorm[6:0] != 7'd0) || s2.inorm[8]);
		sgl = {8'(s2.iexp) + 8'd127, s2.inorm[30:8]} + {30'b0, rnd};
		neg16 = 16'(~s2.fmag[15:0] + 16'd1);
		s3.bits = 64'd0;
		s3.flag = 1'b0;
		s3.last = s2.last;
		case (s2.dst)
			DST_F64: begin
				if (!s2.izero)
					s3.bits = {s2.sign, 11'(s2.iexp) + 11'd1023, s2.inorm[30:0], 21'b0};
			end
			DST_F32: begin
				if (!s2.izero) s3.bits = {32'b0, s2.sign, sgl};
			end
			DST_U32, DST_U8: begin
				if (s2.nan) begin
					s3.flag = 1'b1;
				end else if (s2.sign) begin
					s3.flag = s2.fbig || (s2.fmag != 32'd0);
				end else if (s2.dst == DST_U32) begin
					s3.flag = s2.fbig;
					s3.bits = s2.fbig ? 64'hffff_ffff : {32'b0, s2.fmag};
				end else begin
					s3.flag = s2.fbig || (s2.fmag > 32'd255);
					s3.bits = s3.flag ? 64'hff : {56'b0, s2.fmag[7:0]};
				end
			end
			DST_I16: begin
				if (s2.nan) begin
					s3.flag = 1'b1;
				end else if (s2.sign) begin
					s3.flag = s2.fbig || (s2.fmag > 32'd32768);
					s3.bits = s3.flag ? 64'h8000 : {48'b0, neg16};
				end else begin
					s3.flag = s2.fbig || (s2.fmag > 32'd32767);
					s3.bits = s3.flag ? 64'h7fff : {48'b0, s2.fmag[15:0]};
				end
			end
			default: s3.flag = 1'b1;
		endcase
	end
endmodule

FILE: sv/numeric_format_converter.sv
`timescale 1ns / 1ps
// numeric_format_converter: top level, mode register and three-stage pipeline
// depends on nfc_pkg, nfc_unpack, nfc_align, nfc_pack
//
// channel  handshake              payload
// in       in_valid / in_stall    source_bits, last_in
// out      out_valid / out_stall  result_bits, out_of_range, last_out
// cfg      cfg_we                 cfg_wdata
//
// one word per cycle while the output is not stalled; each word passes registers r_s1, r_s2 and r_s3 (output)
// stage 1 unpack and count leading zeros, stage 2 shift, stage 3 round and saturate
// arst_n clears the valid bits and the mode register
// a stage holds while the stage after it is full and stalled

module numeric_format_converter import nfc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [ModeW-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [63:0]      source_bits,
	input  logic             last_in,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [63:0]      result_bits,
	output logic             out_of_range,
	output logic             last_out
);
	logic [ModeW-1:0] mode_q;
	logic             v_s1, v_s2, v_s3;
	logic             rdy1, rdy2, rdy3;
	s1_t              d1, r_s1;
	s2_t              d2, r_s2;
	s3_t              d3, r_s3;

	assign rdy3 = !v_s3 || !out_stall;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	nfc_unpack u_unpack (.mode(mode_q), .source_bits(source_bits), .last_in(last_in), .s1(d1));
	nfc_align u_align (.s1(r_s1), .s2(d2));
	nfc_pack u_pack (.s2(r_s2), .s3(d3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (cfg_we) mode_q <= cfg_wdata;
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) r_s1 <= d1;
		if (rdy2) r_s2 <= d2;
		if (rdy3) r_s3 <= d3;
	end

	assign out_valid = v_s3;
	assign result_bits = r_s3.bits;
	assign out_of_range = r_s3.flag;
	assign last_out = r_s3.last;
endmodule

FILE: tb/numeric_format_converter_tb.sv
`timescale 1ns / 1ps
// numeric_format_converter_tb: self-checking bench for the numeric format converter
// drives words under every mode setting and compares each result with its own bit-level prediction
// depends on nfc_pkg and numeric_format_converter

module numeric_format_converter_tb import nfc_pkg::*;;

	typedef struct {
		logic [63:0] bits;
		logic        flag;
		logic        last;
	} conv_word_t;

	class conv_scoreboard;
		logic [ModeW-1:0] mode;
		conv_word_t       pending[$];
		int unsigned      mismatches;
		int unsigned      checked;

		function new();
			mode = MODE_U8_F64;
			mismatches = 0;
			checked = 0;
		endfunction

		function int msb_pos(logic [31:0] m);
			int p;
			p = 0;
			for (int i = 0; i < 32; i++) begin
				if (m[i]) p = i;
			end
			return p;
		endfunction

		function logic [63:0] int_to_f64(logic neg, logic [31:0] m);
			int p;
			logic [63:0] sh;
			if (m == 0) return 64'd0;
			p = msb_pos(m);
			sh = 64'(m) << (52 - p);
			return {neg, 11'(1023 + p), sh[51:0]};
		endfunction

		function logic [63:0] int_to_f32(logic neg, logic [31:0] m);
			int p;
			int s;
			logic [31:0] kept;
			logic [31:0] rem;
			logic [31:0] half;
			if (m == 0) return 64'd0;
			p = msb_pos(m);
			if (p <= 23) begin
				kept = m << (23 - p);
			end else begin
				s = p - 23;
				kept = m >> s;
				rem = m & ((32'd1 << s) - 1);
				half = 32'd1 << (s - 1);
				if (rem > half || (rem == half && kept[0])) kept = kept + 1;
				if (kept[24]) begin
					kept = kept >> 1;
					p = p + 1;
				end
			end
			return {32'd0, neg, 8'(127 + p), kept[22:0]};
		endfunction

		// truncate toward zero, saturate to [lo, hi]
		function void float_to_int(logic neg, logic is_nan, logic is_inf, int u,
				logic [52:0] mant, logic to_i16, logic [63:0] hi,
				output logic [63:0] r, output logic flag);
			logic [63:0] t;
			logic huge;
			huge = is_inf;
			t = 0;
			flag = 0;
			if (!is_inf) begin
				if (u >= 40) huge = 1;
				else if (u >= 0) t = 64'(mant) >> (52 - u);
			end
			if (is_nan) begin
				r = 0;
				flag = 1;
			end else if (!neg) begin
				if (huge || t > hi) begin
					r = hi;
					flag = 1;
				end else r = t;
			end else if (huge || t > (to_i16 ? 64'd32768 : 64'd0)) begin
				r = to_i16 ? 64'h8000 : 64'd0;
				flag = 1;
			end else begin
				r = to_i16 ? ((~t + 1) & 64'hFFFF) : 64'd0;
			end
		endfunction

		function conv_word_t convert(logic [63:0] s, logic last);
			conv_word_t w;
			logic d_nan, d_inf, f_nan, f_inf;
			int du, fu;
			logic [52:0] dm, fm;
			logic [15:0] h;
			d_nan = s[62:52] == 11'h7FF && s[51:0] != 0;
			d_inf = s[62:52] == 11'h7FF && s[51:0] == 0;
			du = int'(s[62:52]) - 1023;
			dm = {1'b1, s[51:0]};
			f_nan = s[30:23] == 8'hFF && s[22:0] != 0;
			f_inf = s[30:23] == 8'hFF && s[22:0] == 0;
			fu = int'(s[30:23]) - 127;
			fm = {1'b1, s[22:0], 29'd0};
			h = s[15] ? (~s[15:0] + 16'd1) : s[15:0];
			w.bits = 0;
			w.flag = 0;
			w.last = last;
			case (mode)
				MODE_U8_F64:  w.bits = int_to_f64(1'b0, 32'(s[7:0]));
				MODE_I16_F64: w.bits = int_to_f64(s[15], 32'(h));
				MODE_U32_F64: w.bits = int_to_f64(1'b0, s[31:0]);
				MODE_U8_F32:  w.bits = int_to_f32(1'b0, 32'(s[7:0]));
				MODE_I16_F32: w.bits = int_to_f32(s[15], 32'(h));
				MODE_U32_F32: w.bits = int_to_f32(1'b0, s[31:0]);
				MODE_F64_U32: float_to_int(s[63], d_nan, d_inf, du, dm, 1'b0,
						64'hFFFF_FFFF, w.bits, w.flag);
				MODE_F64_U8:  float_to_int(s[63], d_nan, d_inf, du, dm, 1'b0,
						64'd255, w.bits, w.flag);
				MODE_F64_I16: float_to_int(s[63], d_nan, d_inf, du, dm, 1'b1,
						64'd32767, w.bits, w.flag);
				MODE_F32_U32: float_to_int(s[31], f_nan, f_inf, fu, fm, 1'b0,
						64'hFFFF_FFFF, w.bits, w.flag);
				MODE_F32_U8:  float_to_int(s[31], f_nan, f_inf, fu, fm, 1'b0,
						64'd255, w.bits, w.flag);
				MODE_F32_I16: float_to_int(s[31], f_nan, f_inf, fu, fm, 1'b1,
						64'd32767, w.bits, w.flag);
				default: w.flag = 1;
			endcase
			return w;
		endfunction

		function void note_word(logic [63:0] s, logic last);
			pending.push_back(convert(s, last));
		endfunction

		function void check_word(logic [63:0] bits, logic flag, logic last);
			conv_word_t e;
			checked++;
			if (pending.size() == 0) begin
				$error("unexpected word: result_bits %h", bits);
				mismatches++;
				return;
			end
			e = pending.pop_front();
			if (bits !== e.bits) begin
				$error("result_bits expected %h actual %h (mode %0d)", e.bits, bits, mode);
				mismatches++;
			end
			if (flag !== e.flag) begin
				$error("out_of_range expected %b actual %b (mode %0d)", e.flag, flag, mode);
				mismatches++;
			end
			if (last !== e.last) begin
				$error("last_out expected %b actual %b", e.last, last);
				mismatches++;
			end
		endfunction
	endclass

	localparam int unsigned CycleLimit = 400000;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [ModeW-1:0] cfg_wdata;
	logic             in_valid;
	logic             in_stall;
	logic [63:0]      source_bits;
	logic             last_in;
	logic             out_valid;
	logic             out_stall;
	logic [63:0]      result_bits;
	logic             out_of_range;
	logic             last_out;

	conv_scoreboard   sb;
	int unsigned      cycles;
	int unsigned      sent;
	logic             hold_req;
	logic             calm;

	numeric_format_converter i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .source_bits(source_bits),
		.last_in(last_in), .out_valid(out_valid), .out_stall(out_stall),
		.result_bits(result_bits), .out_of_range(out_of_range), .last_out(last_out)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
		if (arst_n && out_valid && !out_stall)
			sb.check_word(result_bits, out_of_range, last_out);
	end

	// receiver stall pattern, with one long hold-off on request
	initial begin
		int run;
		int pct;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (300) @(negedge clk);
				hold_req = 1'b0;
			end
			run = $urandom_range(4, 40);
			pct = calm ? 0 : $urandom_range(0, 70);
			for (int i = 0; i < run && !hold_req; i++) begin
				out_stall <= ($urandom_range(0, 99) < pct);
				@(negedge clk);
			end
		end
	end

	function automatic logic [63:0] pick_source();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1: ;
			2: r[62:52] = 11'h7FF;
			3: r[30:23] = 8'hFF;
			default: begin
				r[62:52] = 11'(1023 + $urandom_range(0, 44) - 4);
				r[30:23] = 8'(127 + $urandom_range(0, 44) - 4);
				if ($urandom_range(0, 3) == 0) begin
					r[51:0] = 0;
					r[22:0] = 0;
				end
			end
		endcase
		return r;
	endfunction

	task automatic write_mode(logic [ModeW-1:0] m);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		sb.mode = m;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_word(logic [63:0] s, logic last);
		@(negedge clk);
		in_valid <= 1'b1;
		source_bits <= s;
		last_in <= last;
		do @(posedge clk); while (in_stall);
		sb.note_word(s, last);
		sent++;
	endtask

	task automatic idle_sender(int n);
		for (int i = 0; i < n; i++) begin
			@(negedge clk);
			in_valid <= 1'b0;
			source_bits <= {$urandom, $urandom};
		end
	endtask

	task automatic drain();
		idle_sender(1);
		while (sb.pending.size() != 0) @(posedge clk);
		idle_sender(6);
	endtask

	logic [63:0] edge_vals[$] = '{
		64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h80, 64'h7FFF, 64'h8000, 64'hFFFF_FFFF,
		64'h7F80_0000, 64'hFF80_0000, 64'h7FC0_0000, 64'h437F_8000, 64'hBF00_0000,
		64'h4700_0000, 64'hC700_0000, 64'hC700_0100, 64'h7FF0_0000_0000_0000,
		64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001, 64'h41EF_FFFF_FFE0_0000,
		64'h41F0_0000_0000_0000, 64'hBFF0_0000_0000_0000, 64'hBFEC_CCCC_CCCC_CCCD,
		64'hABCD_0000_0100_0001, 64'h0100_0003, 64'h8000_0000_0000_0000
	};

	initial begin
		int burst;
		sb = new();
		sent = 0;
		hold_req = 1'b0;
		calm = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		source_bits = '0;
		last_in = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// reset mode first, then every code including the unused ones
		for (int ph = -1; ph < 16; ph++) begin
			if (ph >= 0) begin
				drain();
				write_mode(ModeW'(ph));
			end
			calm = (ph % 4 == 1);
			if (ph <= 0 || ph == 15)
				foreach (edge_vals[i]) send_word(edge_vals[i], i[0]);
			if (ph == 6) hold_req = 1'b1;
			for (int n = 0; n < 85; ) begin
				burst = $urandom_range(1, 16);
				for (int b = 0; b < burst && n < 85; b++, n++)
					send_word(pick_source(), $urandom_range(0, 7) == 0);
				if (!calm) idle_sender($urandom_range(0, 6));
			end
		end
		drain();
		repeat (10) @(posedge clk);
		$display("sent %0d words over reset mode and all 16 mode codes", sent);
		$display("checked %0d results, %0d field mismatches", sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: files.f
sv/nfc_pkg.sv
sv/nfc_unpack.sv
sv/nfc_align.sv
sv/nfc_pack.sv
sv/numeric_format_converter.sv
tb/numeric_format_converter_tb.sv
